FILE: rtl/core/rsi_pkg.sv
package rsi_pkg;

	localparam int FRAC     = 16;
	localparam int SQ_STEPS = 36;
	localparam int H_W      = 2 * SQ_STEPS;

	localparam logic [2:0] ADDR_RADIUS     = 3'd0;
	localparam logic [2:0] ADDR_INV_RADIUS = 3'd4;

	localparam logic signed [17:0] NORM_LIM = 18'sd65536;

	typedef struct packed {
		logic signed [31:0] ox;
		logic signed [31:0] oy;
		logic signed [31:0] oz;
		logic signed [17:0] dx;
		logic signed [17:0] dy;
		logic signed [17:0] dz;
		logic [30:0]        lim;
		logic [30:0]        lo;
		logic [30:0]        hi;
	} ray_t;

	typedef struct packed {
		logic               miss;
		logic signed [35:0] dot;
		ray_t               ray;
	} sq_side_t;

endpackage

FILE: rtl/core/rsi_front.sv
module rsi_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 in_v,
	input  rsi_pkg::ray_t        in_ray,
	input  logic [30:0]          radius,
	output logic                 out_v,
	output rsi_pkg::sq_side_t    out_side,
	output logic [rsi_pkg::H_W-1:0] out_h
);
	import rsi_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	ray_t ray_s1, ray_s2, ray_s3, ray_s4, ray_s5;
	logic signed [49:0] pdx_s1, pdy_s1, pdz_s1;
	logic [62:0] pox_s1, poy_s1, poz_s1;
	logic [61:0] r2_s1, r2_s2, r2_s3;
	logic signed [35:0] dot_s2, dot_s3, dot_s4, dot_s5;
	logic [63:0] oo_s2, oo_s3, oo_s4;
	logic [71:0] mag2_s3, a_s4;
	logic        miss_s5;
	logic [71:0] h_s5;

	logic signed [51:0] dotp;
	logic [35:0] mag;

	always_comb begin
		dotp = 52'(pdx_s1) + 52'(pdy_s1) + 52'(pdz_s1) + 52'(1 << (FRAC - 1));
		mag  = dot_s2[35] ? 36'(-dot_s2) : 36'(dot_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ray_s1 <= in_ray;
			pdx_s1 <= in_ray.ox * in_ray.dx;
			pdy_s1 <= in_ray.oy * in_ray.dy;
			pdz_s1 <= in_ray.oz * in_ray.dz;
			pox_s1 <= 63'(64'(in_ray.ox) * 64'(in_ray.ox));
			poy_s1 <= 63'(64'(in_ray.oy) * 64'(in_ray.oy));
			poz_s1 <= 63'(64'(in_ray.oz) * 64'(in_ray.oz));
			r2_s1  <= radius * radius;

			ray_s2 <= ray_s1;
			dot_s2 <= dotp[51:FRAC];
			oo_s2  <= 64'(pox_s1) + 64'(poy_s1) + 64'(poz_s1);
			r2_s2  <= r2_s1;

			ray_s3  <= ray_s2;
			dot_s3  <= dot_s2;
			oo_s3   <= oo_s2;
			r2_s3   <= r2_s2;
			mag2_s3 <= mag * mag;

			ray_s4 <= ray_s3;
			dot_s4 <= dot_s3;
			oo_s4  <= oo_s3;
			a_s4   <= mag2_s3 + 72'(r2_s3);

			ray_s5  <= ray_s4;
			dot_s5  <= dot_s4;
			miss_s5 <= 72'(oo_s4) > a_s4;
			h_s5    <= a_s4 - 72'(oo_s4);
		end
	end

	assign out_v         = v_s5;
	assign out_side.miss = miss_s5;
	assign out_side.dot  = dot_s5;
	assign out_side.ray  = ray_s5;
	assign out_h         = h_s5;

endmodule

FILE: rtl/core/rsi_sqrt.sv
module rsi_sqrt (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  logic                    in_v,
	input  rsi_pkg::sq_side_t       in_side,
	input  logic [rsi_pkg::H_W-1:0] in_h,
	output logic                    out_v,
	output rsi_pkg::sq_side_t       out_side,
	output logic [rsi_pkg::SQ_STEPS-1:0] out_s
);
	import rsi_pkg::*;

	// Digit-by-digit square root, one result bit per stage.
	logic              v_s    [SQ_STEPS+1];
	sq_side_t          side_s [SQ_STEPS+1];
	logic [H_W-1:0]    h_s    [SQ_STEPS+1];
	logic [SQ_STEPS:0] rem_s  [SQ_STEPS+1];
	logic [SQ_STEPS-1:0] root_s [SQ_STEPS+1];

	assign v_s[0]    = in_v;
	assign side_s[0] = in_side;
	assign h_s[0]    = in_h;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;

	for (genvar g = 0; g < SQ_STEPS; g++) begin : g_step
		logic [SQ_STEPS+2:0] cur;
		logic [SQ_STEPS+2:0] trial;
		logic                ge;

		always_comb begin
			cur   = {rem_s[g], h_s[g][H_W-1 -: 2]};
			trial = {1'b0, root_s[g], 2'b01};
			ge    = cur >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (adv) begin
				v_s[g+1] <= v_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				side_s[g+1] <= side_s[g];
				h_s[g+1]    <= {h_s[g][H_W-3:0], 2'b00};
				rem_s[g+1]  <= ge ? (SQ_STEPS+1)'(cur - trial) : (SQ_STEPS+1)'(cur);
				root_s[g+1] <= {root_s[g][SQ_STEPS-2:0], ge};
			end
		end
	end

	assign out_v    = v_s[SQ_STEPS];
	assign out_side = side_s[SQ_STEPS];
	assign out_s    = root_s[SQ_STEPS];

endmodule

FILE: rtl/core/rsi_back.sv
module rsi_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic                         in_v,
	input  rsi_pkg::sq_side_t            in_side,
	input  logic [rsi_pkg::SQ_STEPS-1:0] in_s,
	input  logic [30:0]                  inv_radius,
	output logic                         out_v,
	output logic                         hit,
	output logic [30:0]                  t_hit,
	output logic signed [31:0]           point_x,
	output logic signed [31:0]           point_y,
	output logic signed [31:0]           point_z,
	output logic signed [17:0]           normal_x,
	output logic signed [17:0]           normal_y,
	output logic signed [17:0]           normal_z
);
	import rsi_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	ray_t ray_s1, ray_s2, ray_s3;
	logic miss_s1;
	logic signed [37:0] tmin_s1, tmax_s1;
	logic hit_s2, hit_s3, hit_s4, hit_s5;
	logic [30:0] t_s2, t_s3, t_s4, t_s5;
	logic signed [49:0] ptx_s3, pty_s3, ptz_s3;
	logic signed [31:0] px_s4, py_s4, pz_s4, px_s5, py_s5, pz_s5;
	logic signed [63:0] pnx_s5, pny_s5, pnz_s5;

	logic signed [37:0] dot_w, s_w, lim_w, lo_w, hi_w, t_sel;
	logic               ok;
	logic signed [31:0] px_n, py_n, pz_n;
	logic signed [17:0] nx_n, ny_n, nz_n;
	logic signed [31:0] inv_w;

	function automatic logic signed [31:0] pt_sat(input logic signed [31:0] o,
			input logic signed [49:0] pt);
		logic signed [50:0] r;
		logic signed [35:0] sum;
		begin
			r   = 51'(pt) + 51'(1 << (FRAC - 1));
			sum = 36'(o) + 36'($signed(r[50:FRAC]));
			if (sum > 36'sh0_7FFF_FFFF)
				pt_sat = 32'sh7FFF_FFFF;
			else if (sum < -36'sh0_8000_0000)
				pt_sat = -32'sh8000_0000;
			else
				pt_sat = sum[31:0];
		end
	endfunction

	function automatic logic signed [17:0] nrm_clamp(input logic signed [63:0] pn);
		logic signed [64:0] r;
		logic signed [48:0] q;
		begin
			r = 65'(pn) + 65'(1 << (FRAC - 1));
			q = r[64:FRAC];
			if (q > 49'(NORM_LIM))
				nrm_clamp = NORM_LIM;
			else if (q < -49'(NORM_LIM))
				nrm_clamp = -NORM_LIM;
			else
				nrm_clamp = q[17:0];
		end
	endfunction

	always_comb begin
		dot_w = 38'(in_side.dot);
		s_w   = 38'({1'b0, in_s});
		lim_w = 38'({1'b0, ray_s1.lim});
		lo_w  = 38'({1'b0, ray_s1.lo});
		hi_w  = 38'({1'b0, ray_s1.hi});
		ok    = 1'b0;
		t_sel = tmax_s1;
		// Near root when it lies ahead of the origin, else the far root.
		if (tmin_s1 > lim_w || tmax_s1 <= 38'sd0) begin
			ok = 1'b0;
		end else if (tmin_s1 > 38'sd0) begin
			ok    = 1'b1;
			t_sel = tmin_s1;
		end else begin
			ok = tmax_s1 <= lim_w;
		end
		if (t_sel > hi_w || t_sel < lo_w)
			ok = 1'b0;
		inv_w = 32'({1'b0, inv_radius});
		px_n  = pt_sat(ray_s3.ox, ptx_s3);
		py_n  = pt_sat(ray_s3.oy, pty_s3);
		pz_n  = pt_sat(ray_s3.oz, ptz_s3);
		nx_n  = nrm_clamp(pnx_s5);
		ny_n  = nrm_clamp(pny_s5);
		nz_n  = nrm_clamp(pnz_s5);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ray_s1  <= in_side.ray;
			miss_s1 <= in_side.miss;
			tmin_s1 <= -dot_w - s_w;
			tmax_s1 <= -dot_w + s_w;

			ray_s2 <= ray_s1;
			hit_s2 <= ok && !miss_s1;
			t_s2   <= t_sel[30:0];

			ray_s3 <= ray_s2;
			hit_s3 <= hit_s2;
			t_s3   <= t_s2;
			ptx_s3 <= $signed({1'b0, t_s2}) * ray_s2.dx;
			pty_s3 <= $signed({1'b0, t_s2}) * ray_s2.dy;
			ptz_s3 <= $signed({1'b0, t_s2}) * ray_s2.dz;

			hit_s4 <= hit_s3;
			t_s4   <= t_s3;
			px_s4  <= px_n;
			py_s4  <= py_n;
			pz_s4  <= pz_n;

			hit_s5 <= hit_s4;
			t_s5   <= t_s4;
			px_s5  <= px_s4;
			py_s5  <= py_s4;
			pz_s5  <= pz_s4;
			pnx_s5 <= px_s4 * inv_w;
			pny_s5 <= py_s4 * inv_w;
			pnz_s5 <= pz_s4 * inv_w;

			// A miss gives all-zero fields.
			hit      <= hit_s5;
			t_hit    <= hit_s5 ? t_s5 : '0;
			point_x  <= hit_s5 ? px_s5 : '0;
			point_y  <= hit_s5 ? py_s5 : '0;
			point_z  <= hit_s5 ? pz_s5 : '0;
			normal_x <= hit_s5 ? nx_n : '0;
			normal_y <= hit_s5 ? ny_n : '0;
			normal_z <= hit_s5 ? nz_n : '0;
		end
	end

	assign out_v = v_s6;

endmodule

FILE: rtl/core/ray_sphere_intersect.sv
// Pipeline: 5 front stages, 36 square-root stages and 6 back stages lie between
// an accepted input beat and its result beat.
// Throughput: one ray per cycle; the pipeline holds as a whole only while a
// finished result is stalled at the output register.
// Reset clears all valid bits and sets radius and inv_radius to 1.0.
module ray_sphere_intersect (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] origin_x,
	input  logic signed [31:0] origin_y,
	input  logic signed [31:0] origin_z,
	input  logic signed [17:0] dir_x,
	input  logic signed [17:0] dir_y,
	input  logic signed [17:0] dir_z,
	input  logic [30:0]        t_limit,
	input  logic [30:0]        t_low,
	input  logic [30:0]        t_high,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               hit,
	output logic [30:0]        t_hit,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic signed [31:0] point_z,
	output logic signed [17:0] normal_x,
	output logic signed [17:0] normal_y,
	output logic signed [17:0] normal_z
);
	import rsi_pkg::*;

	logic [30:0] radius_q, inv_radius_q;
	logic        adv;
	ray_t        ray_in;
	logic        f_v, q_v;
	sq_side_t    f_side, q_side;
	logic [H_W-1:0]      f_h;
	logic [SQ_STEPS-1:0] q_s;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q     <= 31'd65536;
			inv_radius_q <= 31'd65536;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == ADDR_RADIUS[2])
				radius_q <= pwdata[30:0];
			else
				inv_radius_q <= pwdata[30:0];
		end
	end

	assign prdata = (paddr[2] == ADDR_INV_RADIUS[2]) ? {1'b0, inv_radius_q}
							   : {1'b0, radius_q};

	// Every stage moves on unless the result register holds a stalled beat.
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	assign ray_in = '{ox: origin_x, oy: origin_y, oz: origin_z,
			dx: dir_x, dy: dir_y, dz: dir_z,
			lim: t_limit, lo: t_low, hi: t_high};

	rsi_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_v     (in_valid),
		.in_ray   (ray_in),
		.radius   (radius_q),
		.out_v    (f_v),
		.out_side (f_side),
		.out_h    (f_h)
	);

	rsi_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_v     (f_v),
		.in_side  (f_side),
		.in_h     (f_h),
		.out_v    (q_v),
		.out_side (q_side),
		.out_s    (q_s)
	);

	rsi_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.in_v       (q_v),
		.in_side    (q_side),
		.in_s       (q_s),
		.inv_radius (inv_radius_q),
		.out_v      (out_valid),
		.hit        (hit),
		.t_hit      (t_hit),
		.point_x    (point_x),
		.point_y    (point_y),
		.point_z    (point_z),
		.normal_x   (normal_x),
		.normal_y   (normal_y),
		.normal_z   (normal_z)
	);

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> t_hit == '0 && point_x == '0 && normal_x == '0)
		else $error("miss result carries non-zero fields");

	a_hit_ahead: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> t_hit != '0)
		else $error("hit at non-positive distance");

	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> normal_x <= NORM_LIM && normal_x >= -NORM_LIM
			&& normal_y <= NORM_LIM && normal_y >= -NORM_LIM
			&& normal_z <= NORM_LIM && normal_z >= -NORM_LIM)
		else $error("normal component out of range");

endmodule
